// File: design/spcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcp_pkg
// Shared widths, payload types and codes for the segment pair closest points
// block.
// ----------------------------------------------------------------------------
package spcp_pkg;

    localparam int CW     = 24;            // coordinate width, Q11.12
    localparam int DW     = CW + 1;        // coordinate difference
    localparam int PW     = 2 * DW;        // product of two differences
    localparam int DOTW   = PW + 2;        // three-term dot product
    localparam int HALF   = DOTW / 2;      // low slice of a split multiply
    localparam int HI     = DOTW - HALF;   // high slice
    localparam int PRODW  = 2 * DOTW;      // product of two dot products
    localparam int DIVW   = PRODW + 1;     // divider operand
    localparam int NCW    = DOTW + 1;      // -c and b-c
    localparam int QBITS  = 16;            // fraction bits of s and t
    localparam int QW     = QBITS + 1;     // s and t, 0 .. 1.0
    localparam int BSW    = DOTW + QW + 1; // b * s
    localparam int TW     = BSW + 1;       // b * s + f * 1.0
    localparam int MW     = DW + QW + 1;   // d * s
    localparam int OW     = DW + 1;        // floored offset
    localparam int THRW   = 32;
    localparam int CODEW  = 3;
    localparam int DIV_LAT = QBITS + 2;
    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [QW-1:0]   ONE_Q         = QW'(1) << QBITS;
    localparam logic [THRW-1:0] THRESHOLD_RST = THRW'(2);

    typedef enum logic [CODEW-1:0] {
        CASE_BOTH     = 3'd0,
        CASE_FIRST    = 3'd1,
        CASE_SECOND   = 3'd2,
        CASE_PARALLEL = 3'd3,
        CASE_GENERAL  = 3'd4
    } t_case_code;

    // outcome of the t recompute
    typedef enum logic [1:0] {
        BR_MID  = 2'd0,
        BR_NEG  = 2'd1,
        BR_HIGH = 2'd2
    } t_branch;

    typedef struct packed {
        logic signed [CW-1:0] a1_x;
        logic signed [CW-1:0] a1_y;
        logic signed [CW-1:0] a1_z;
        logic signed [CW-1:0] b1_x;
        logic signed [CW-1:0] b1_y;
        logic signed [CW-1:0] b1_z;
        logic signed [CW-1:0] a2_x;
        logic signed [CW-1:0] a2_y;
        logic signed [CW-1:0] a2_z;
        logic signed [CW-1:0] b2_x;
        logic signed [CW-1:0] b2_y;
        logic signed [CW-1:0] b2_z;
    } t_seg_in;

    typedef struct packed {
        logic signed [CW-1:0] near1_x;
        logic signed [CW-1:0] near1_y;
        logic signed [CW-1:0] near1_z;
        logic signed [CW-1:0] near2_x;
        logic signed [CW-1:0] near2_y;
        logic signed [CW-1:0] near2_z;
        logic [CODEW-1:0]     case_code;
    } t_seg_out;

    // one classified item, as queued between front and back
    typedef struct packed {
        logic [2:0][CW-1:0]     a1;
        logic [2:0][CW-1:0]     a2;
        logic [2:0][DW-1:0]     d1;
        logic [2:0][DW-1:0]     d2;
        logic signed [DOTW-1:0] a;
        logic signed [DOTW-1:0] b;
        logic signed [DOTW-1:0] c;
        logic signed [DOTW-1:0] e;
        logic signed [DOTW-1:0] f;
        logic                   pa;
        logic                   pe;
    } t_item_ctx;

    typedef struct packed {
        logic       v;
        t_item_ctx  item;
        t_case_code code;
        t_branch    br;
        logic [QW-1:0] q1;
    } t_back_ctx;

endpackage

// File: design/segment_pair_closest_points.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_pair_closest_points
// Closest points between two 3D segments in Q11.12, with a case code.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the twelve endpoint coordinates on i_item and raise start; the beat
//   is taken at an edge where start is high and busy is low. busy stays low
//   in steady streaming, so a new pair can go in every cycle.
//   Each pair gives one result beat: o_done is high for one cycle with the two
//   points and case code on o_result. The path runs through the dot-product
//   front end, the 26-bit split wide multiplies and the two 18-stage ratio
//   pipelines in the back end.
//   Results leave in input order; the sink cannot stall, so o_done is never
//   held off. A queue of QDEPTH entries sits between front and back.
//   The squared length threshold is written through i_cfg_valid/o_cfg_ready
//   with i_cfg_data; write it only while no pair is in flight.
//   Reset (i_rst_n low, synchronous) empties all stages and sets the
//   threshold to 2.
// ----------------------------------------------------------------------------
module segment_pair_closest_points (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  spcp_pkg::t_seg_in           i_item,
    output logic                        busy,
    output logic                        o_done,
    output spcp_pkg::t_seg_out          o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [spcp_pkg::THRW-1:0]   i_cfg_data
);
    import spcp_pkg::*;

    logic [THRW-1:0] r_threshold;
    logic            push, q_valid, pop;
    t_item_ctx       push_data, q_data;
    logic [QCW-1:0]  q_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_threshold <= i_cfg_data;
        end
    end

    spcp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .i_threshold (r_threshold),
        .i_q_level   (q_level),
        .o_busy      (busy),
        .o_push      (push),
        .o_entry     (push_data)
    );

    spcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_valid (q_valid),
        .o_level (q_level)
    );

    spcp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_entry  (q_data),
        .o_pop    (pop),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

// File: design/spcp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcp_div
// Pipelined clamped Q1.16 ratio: one quotient bit per stage.
// ----------------------------------------------------------------------------
module spcp_div (
    input  logic                              i_clk,
    input  logic signed [spcp_pkg::DIVW-1:0]  i_num,
    input  logic signed [spcp_pkg::DIVW-1:0]  i_den,
    output logic [spcp_pkg::QW-1:0]           o_quot
);
    import spcp_pkg::*;

    logic [DIVW-1:0]  n_an, n_ad;
    logic             n_az;
    logic [DIVW-1:0]  r_an, r_ad;
    logic             r_az;

    logic [DIVW-1:0]  r_rem [QBITS+1];
    logic [DIVW-1:0]  r_den [QBITS+1];
    logic [QBITS-1:0] r_q   [QBITS+1];
    logic             r_z   [QBITS+1];
    logic             r_o   [QBITS+1];

    logic [DIVW:0]    sh    [QBITS];
    logic             ge    [QBITS];

    always_comb begin
        // zero on a zero operand or opposite signs
        n_az = (i_num == '0) || (i_den == '0) || (i_num[DIVW-1] != i_den[DIVW-1]);
        n_an = i_num[DIVW-1] ? DIVW'(-i_num) : DIVW'(i_num);
        n_ad = i_den[DIVW-1] ? DIVW'(-i_den) : DIVW'(i_den);
        for (int k = 0; k < QBITS; k++) begin
            sh[k] = {r_rem[k], 1'b0};
            ge[k] = sh[k] >= {1'b0, r_den[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_an <= n_an;
        r_ad <= n_ad;
        r_az <= n_az;
        r_rem[0] <= r_an;
        r_den[0] <= r_ad;
        r_q[0]   <= '0;
        r_z[0]   <= r_az;
        r_o[0]   <= r_an >= r_ad;
        for (int k = 0; k < QBITS; k++) begin
            r_rem[k+1] <= ge[k] ? DIVW'(sh[k] - {1'b0, r_den[k]}) : sh[k][DIVW-1:0];
            r_den[k+1] <= r_den[k];
            r_q[k+1]   <= {r_q[k][QBITS-2:0], ge[k]};
            r_z[k+1]   <= r_z[k];
            r_o[k+1]   <= r_o[k];
        end
    end

    assign o_quot = r_z[QBITS] ? '0 : (r_o[QBITS] ? ONE_Q : {1'b0, r_q[QBITS]});

endmodule

// File: design/spcp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcp_front
// Takes input beats, forms differences and dot products, flags degenerate
// segments and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module spcp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  spcp_pkg::t_seg_in             i_item,
    input  logic [spcp_pkg::THRW-1:0]     i_threshold,
    input  logic [spcp_pkg::QCW-1:0]      i_q_level,
    output logic                          o_busy,
    output logic                          o_push,
    output spcp_pkg::t_item_ctx           o_entry
);
    import spcp_pkg::*;

    logic [2:0][CW-1:0] in_a1, in_b1, in_a2, in_b2;
    logic [2:0][DW-1:0] n_d1, n_d2, n_r;
    logic [2:0][PW-1:0] n_p_aa, n_p_ee, n_p_ff, n_p_cc, n_p_bb;
    logic signed [DOTW-1:0] n_a, n_b, n_c, n_e, n_f;
    logic [QCW:0] occ;
    logic accept;

    logic r_f1_v, r_f2_v, r_f3_v;
    logic [2:0][CW-1:0] r_f1_a1, r_f1_a2, r_f2_a1, r_f2_a2, r_f3_a1, r_f3_a2;
    logic [2:0][DW-1:0] r_f1_d1, r_f1_d2, r_f1_r, r_f2_d1, r_f2_d2, r_f3_d1, r_f3_d2;
    logic [2:0][PW-1:0] r_p_aa, r_p_ee, r_p_ff, r_p_cc, r_p_bb;
    logic signed [DOTW-1:0] r_a, r_b, r_c, r_e, r_f;

    // items in flight count against the queue so a push always fits
    assign occ    = (QCW+1)'(i_q_level) + (QCW+1)'(r_f1_v) + (QCW+1)'(r_f2_v)
                  + (QCW+1)'(r_f3_v);
    assign o_busy = occ >= (QCW+1)'(QDEPTH);
    assign accept = i_start && !o_busy;

    always_comb begin
        in_a1 = {i_item.a1_z, i_item.a1_y, i_item.a1_x};
        in_b1 = {i_item.b1_z, i_item.b1_y, i_item.b1_x};
        in_a2 = {i_item.a2_z, i_item.a2_y, i_item.a2_x};
        in_b2 = {i_item.b2_z, i_item.b2_y, i_item.b2_x};
        for (int i = 0; i < 3; i++) begin
            n_d1[i] = DW'($signed(in_b1[i])) - DW'($signed(in_a1[i]));
            n_d2[i] = DW'($signed(in_b2[i])) - DW'($signed(in_a2[i]));
            n_r[i]  = DW'($signed(in_a1[i])) - DW'($signed(in_a2[i]));
            n_p_aa[i] = $signed(r_f1_d1[i]) * $signed(r_f1_d1[i]);
            n_p_ee[i] = $signed(r_f1_d2[i]) * $signed(r_f1_d2[i]);
            n_p_ff[i] = $signed(r_f1_d2[i]) * $signed(r_f1_r[i]);
            n_p_cc[i] = $signed(r_f1_d1[i]) * $signed(r_f1_r[i]);
            n_p_bb[i] = $signed(r_f1_d1[i]) * $signed(r_f1_d2[i]);
        end
        n_a = DOTW'($signed(r_p_aa[0])) + DOTW'($signed(r_p_aa[1]))
            + DOTW'($signed(r_p_aa[2]));
        n_e = DOTW'($signed(r_p_ee[0])) + DOTW'($signed(r_p_ee[1]))
            + DOTW'($signed(r_p_ee[2]));
        n_f = DOTW'($signed(r_p_ff[0])) + DOTW'($signed(r_p_ff[1]))
            + DOTW'($signed(r_p_ff[2]));
        n_c = DOTW'($signed(r_p_cc[0])) + DOTW'($signed(r_p_cc[1]))
            + DOTW'($signed(r_p_cc[2]));
        n_b = DOTW'($signed(r_p_bb[0])) + DOTW'($signed(r_p_bb[1]))
            + DOTW'($signed(r_p_bb[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
        end else begin
            r_f1_v <= accept;
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_a1 <= in_a1;
        r_f1_a2 <= in_a2;
        r_f1_d1 <= n_d1;
        r_f1_d2 <= n_d2;
        r_f1_r  <= n_r;
        r_f2_a1 <= r_f1_a1;
        r_f2_a2 <= r_f1_a2;
        r_f2_d1 <= r_f1_d1;
        r_f2_d2 <= r_f1_d2;
        r_p_aa  <= n_p_aa;
        r_p_ee  <= n_p_ee;
        r_p_ff  <= n_p_ff;
        r_p_cc  <= n_p_cc;
        r_p_bb  <= n_p_bb;
        r_f3_a1 <= r_f2_a1;
        r_f3_a2 <= r_f2_a2;
        r_f3_d1 <= r_f2_d1;
        r_f3_d2 <= r_f2_d2;
        r_a     <= n_a;
        r_b     <= n_b;
        r_c     <= n_c;
        r_e     <= n_e;
        r_f     <= n_f;
    end

    // a and e are never negative, so an unsigned compare is safe
    always_comb begin
        o_push     = r_f3_v;
        o_entry.a1 = r_f3_a1;
        o_entry.a2 = r_f3_a2;
        o_entry.d1 = r_f3_d1;
        o_entry.d2 = r_f3_d2;
        o_entry.a  = r_a;
        o_entry.b  = r_b;
        o_entry.c  = r_c;
        o_entry.e  = r_e;
        o_entry.f  = r_f;
        o_entry.pa = $unsigned(r_a) <= DOTW'(i_threshold);
        o_entry.pe = $unsigned(r_e) <= DOTW'(i_threshold);
    end

endmodule

// File: design/spcp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcp_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module spcp_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  spcp_pkg::t_item_ctx         i_data,
    input  logic                        i_pop,
    output spcp_pkg::t_item_ctx         o_data,
    output logic                        o_valid,
    output logic [spcp_pkg::QCW-1:0]    o_level
);
    import spcp_pkg::*;

    t_item_ctx        r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QCW-1:0]   r_level;
    logic             do_pop;

    assign o_valid = r_level != '0;
    assign o_level = r_level;
    assign o_data  = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_level <= r_level + QCW'(i_push) - QCW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: design/spcp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcp_back
// Solves for s and t of one queued item per cycle: wide products, first
// ratio, t recompute, second ratio, then the two interpolated points.
// ----------------------------------------------------------------------------
module spcp_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  spcp_pkg::t_item_ctx     i_entry,
    output logic                    o_pop,
    output logic                    o_done,
    output spcp_pkg::t_seg_out      o_result
);
    import spcp_pkg::*;

    t_back_ctx r_c0, r_c1, r_c2, r_c3, r_c4, r_c5, r_c6, r_c7, r_c8, r_c9;
    t_back_ctx r_dl1 [DIV_LAT];
    t_back_ctx r_dl2 [DIV_LAT];
    t_back_ctx n_c4, n_c5, n_c7;

    logic signed [DOTW-1:0]     op_x [4];
    logic signed [DOTW-1:0]     op_y [4];
    logic signed [2*HI-1:0]     n_hh [4];
    logic signed [HI+HALF:0]    n_hl [4];
    logic signed [HI+HALF:0]    n_lh [4];
    logic [2*HALF-1:0]          n_ll [4];
    logic signed [2*HI-1:0]     r_hh [4];
    logic signed [HI+HALF:0]    r_hl [4];
    logic signed [HI+HALF:0]    r_lh [4];
    logic [2*HALF-1:0]          r_ll [4];
    logic signed [PRODW-1:0]    n_prod [4];
    logic signed [PRODW-1:0]    r_prod [4];

    logic signed [DIVW-1:0]     r_denom, r_snum;
    logic signed [DIVW-1:0]     n_n1, n_d1, r_n1, r_d1;
    logic signed [DIVW-1:0]     n_n2, n_d2, r_n2, r_d2;
    logic [QW-1:0]              q1, q2;

    logic signed [BSW-1:0]      r_bs;
    logic signed [TW-1:0]       r_t, r_e16;
    logic signed [NCW-1:0]      r_negc, r_bmc;

    logic [QW-1:0]              n_s, n_t, r_s, r_t8;
    logic signed [MW-1:0]       m1 [3];
    logic signed [MW-1:0]       m2 [3];
    logic [2:0][OW-1:0]         r_off1, r_off2;
    t_seg_out                   n_out, r_out;
    logic                       r_done;

    assign o_pop = i_valid;

    // products: a*e, b*b, b*f, c*e, each from four narrow partials
    always_comb begin
        op_x[0] = r_c0.item.a;  op_y[0] = r_c0.item.e;
        op_x[1] = r_c0.item.b;  op_y[1] = r_c0.item.b;
        op_x[2] = r_c0.item.b;  op_y[2] = r_c0.item.f;
        op_x[3] = r_c0.item.c;  op_y[3] = r_c0.item.e;
        for (int k = 0; k < 4; k++) begin
            n_hh[k] = $signed(op_x[k][DOTW-1:HALF]) * $signed(op_y[k][DOTW-1:HALF]);
            n_hl[k] = $signed(op_x[k][DOTW-1:HALF]) * $signed({1'b0, op_y[k][HALF-1:0]});
            n_lh[k] = $signed({1'b0, op_x[k][HALF-1:0]}) * $signed(op_y[k][DOTW-1:HALF]);
            n_ll[k] = op_x[k][HALF-1:0] * op_y[k][HALF-1:0];
            n_prod[k] = (PRODW'(r_hh[k]) << (2*HALF)) + (PRODW'(r_hl[k]) << HALF)
                      + (PRODW'(r_lh[k]) << HALF) + PRODW'(r_ll[k]);
        end
    end

    // case decode and first ratio operands
    always_comb begin
        n_c4 = r_c3;
        n_n1 = '0;
        n_d1 = '0;
        if (r_c3.item.pa && r_c3.item.pe) begin
            n_c4.code = CASE_BOTH;
        end else if (r_c3.item.pa) begin
            n_c4.code = CASE_FIRST;
            n_n1 = DIVW'(r_c3.item.f);
            n_d1 = DIVW'(r_c3.item.e);
        end else if (r_c3.item.pe) begin
            n_c4.code = CASE_SECOND;
            n_n1 = -DIVW'(r_c3.item.c);
            n_d1 = DIVW'(r_c3.item.a);
        end else if (r_denom == '0) begin
            n_c4.code = CASE_PARALLEL;
        end else begin
            n_c4.code = CASE_GENERAL;
            n_n1 = r_snum;
            n_d1 = r_denom;
        end
    end

    spcp_div u_div1 (
        .i_clk  (i_clk),
        .i_num  (r_n1),
        .i_den  (r_d1),
        .o_quot (q1)
    );

    always_comb begin
        n_c5    = r_dl1[DIV_LAT-1];
        n_c5.q1 = q1;
    end

    // t recompute: clamp low, clamp high or divide
    always_comb begin
        n_c7 = r_c6;
        if (r_t < 0) begin
            n_c7.br = BR_NEG;
            n_n2 = DIVW'(r_negc);
            n_d2 = DIVW'(r_c6.item.a);
        end else if (r_t > r_e16) begin
            n_c7.br = BR_HIGH;
            n_n2 = DIVW'(r_bmc);
            n_d2 = DIVW'(r_c6.item.a);
        end else begin
            n_c7.br = BR_MID;
            n_n2 = DIVW'(r_t);
            n_d2 = DIVW'(r_e16);
        end
    end

    spcp_div u_div2 (
        .i_clk  (i_clk),
        .i_num  (r_n2),
        .i_den  (r_d2),
        .o_quot (q2)
    );

    always_comb begin
        n_s = '0;
        n_t = '0;
        unique case (r_dl2[DIV_LAT-1].code)
            CASE_BOTH: begin
                n_s = '0;
                n_t = '0;
            end
            CASE_FIRST: begin
                n_t = r_dl2[DIV_LAT-1].q1;
            end
            CASE_SECOND: begin
                n_s = r_dl2[DIV_LAT-1].q1;
            end
            default: begin
                unique case (r_dl2[DIV_LAT-1].br)
                    BR_NEG: begin
                        n_s = q2;
                        n_t = '0;
                    end
                    BR_HIGH: begin
                        n_s = q2;
                        n_t = ONE_Q;
                    end
                    default: begin
                        n_s = r_dl2[DIV_LAT-1].q1;
                        n_t = q2;
                    end
                endcase
            end
        endcase
    end

    // floored offsets: arithmetic shift of the signed product
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m1[i] = $signed(r_c8.item.d1[i]) * $signed({1'b0, r_s});
            m2[i] = $signed(r_c8.item.d2[i]) * $signed({1'b0, r_t8});
        end
        n_out.near1_x   = CW'(OW'($signed(r_c9.item.a1[0])) + r_off1[0]);
        n_out.near1_y   = CW'(OW'($signed(r_c9.item.a1[1])) + r_off1[1]);
        n_out.near1_z   = CW'(OW'($signed(r_c9.item.a1[2])) + r_off1[2]);
        n_out.near2_x   = CW'(OW'($signed(r_c9.item.a2[0])) + r_off2[0]);
        n_out.near2_y   = CW'(OW'($signed(r_c9.item.a2[1])) + r_off2[1]);
        n_out.near2_z   = CW'(OW'($signed(r_c9.item.a2[2])) + r_off2[2]);
        n_out.case_code = r_c9.code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0   <= '0;
            r_c1   <= '0;
            r_c2   <= '0;
            r_c3   <= '0;
            r_c4   <= '0;
            r_c5   <= '0;
            r_c6   <= '0;
            r_c7   <= '0;
            r_c8   <= '0;
            r_c9   <= '0;
            r_done <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                r_dl1[k] <= '0;
                r_dl2[k] <= '0;
            end
        end else begin
            r_c0.v    <= i_valid;
            r_c0.item <= i_entry;
            r_c0.code <= CASE_BOTH;
            r_c0.br   <= BR_MID;
            r_c0.q1   <= '0;
            r_c1      <= r_c0;
            r_c2      <= r_c1;
            r_c3      <= r_c2;
            r_c4      <= n_c4;
            r_dl1[0]  <= r_c4;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dl1[k] <= r_dl1[k-1];
                r_dl2[k] <= r_dl2[k-1];
            end
            r_c5      <= n_c5;
            r_c6      <= r_c5;
            r_c7      <= n_c7;
            r_dl2[0]  <= r_c7;
            r_c8      <= r_dl2[DIV_LAT-1];
            r_c9      <= r_c8;
            r_done    <= r_c9.v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_hh[k]   <= n_hh[k];
            r_hl[k]   <= n_hl[k];
            r_lh[k]   <= n_lh[k];
            r_ll[k]   <= n_ll[k];
            r_prod[k] <= n_prod[k];
        end
        r_denom <= DIVW'(r_prod[0]) - DIVW'(r_prod[1]);
        r_snum  <= DIVW'(r_prod[2]) - DIVW'(r_prod[3]);
        r_n1    <= n_n1;
        r_d1    <= n_d1;
        r_bs    <= $signed(r_dl1[DIV_LAT-1].item.b) * $signed({1'b0, q1});
        r_t     <= TW'(r_bs) + (TW'(r_c5.item.f) <<< QBITS);
        r_e16   <= TW'(r_c5.item.e) <<< QBITS;
        r_negc  <= -NCW'(r_c5.item.c);
        r_bmc   <= NCW'(r_c5.item.b) - NCW'(r_c5.item.c);
        r_n2    <= n_n2;
        r_d2    <= n_d2;
        r_s     <= n_s;
        r_t8    <= n_t;
        for (int i = 0; i < 3; i++) begin
            r_off1[i] <= OW'(m1[i] >>> QBITS);
            r_off2[i] <= OW'(m2[i] >>> QBITS);
        end
        r_out   <= n_out;
    end

    assign o_done   = r_done;
    assign o_result = r_out;

endmodule
